### sv/joystick_frame_deframer_defines.svh
// Assertion helpers for the joystick frame deframer.
// Each macro expects aclk and aresetn in scope.
`ifndef JOYSTICK_FRAME_DEFRAMER_DEFINES_SVH
`define JOYSTICK_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define JFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define JFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/jfd_pkg.sv
package jfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAYLOAD_LEN = 5;
    localparam int unsigned SLOT_W      = $clog2(PAYLOAD_LEN);
    localparam int unsigned AXIS_COUNT  = 4;

    // Result word layout, lowest bit first
    localparam int unsigned OUT_READY_BIT   = 0;
    localparam int unsigned OUT_REFUSED_BIT = 1;
    localparam int unsigned OUT_HELD_LSB    = 2;
    localparam int unsigned OUT_USED_W      = OUT_HELD_LSB + PAYLOAD_LEN * BYTE_W;
    localparam int unsigned OUT_DATA_W      = ((OUT_USED_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [BYTE_W-1:0] AXIS_OFFSET     = 8'h80;
    localparam logic [BYTE_W-1:0] CHECK_BASE      = 8'hFF;

    typedef logic [BYTE_W-1:0] byte_t;

    // Command carried in tuser
    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_ACK  = 1'b1
    } cmd_t;

    // Configuration register indexes
    typedef enum logic {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } reg_idx_t;

endpackage

### sv/joystick_frame_deframer.sv
// Joystick frame deframer.
// Input channel (s_): one transfer per received serial byte. s_tuser carries the
// command: data means take s_tdata as the next byte, acknowledge releases the held
// frame. The block hunts for the two sync bytes, collects four axes, buttons, an
// extra byte and a checksum, then latches the axes and buttons for the user.
// Result channel (m_): exactly one transfer per input transfer, carrying the ready
// flag, a refused flag and the held axes (offset to signed) and buttons.
// The result is registered and valid in the cycle after the input transfer. One item
// per cycle unless the output stalls; the parser decodes every byte in the same cycle it is taken.
// While a good frame is held, data bytes are refused and leave the parser untouched.
// Stall: a held result stays in the output register; s_tready drops only while that
// register is full and m_tready is low, so no item is lost.
// Reset (aresetn low, synchronous): hunting, ready clear, held values zero (axes
// read -128), sync bytes back to 0xFF and 0x55, output empty.
// Configuration: cfg_we writes register cfg_index (0 first sync, 1 second sync);
// write only while the block is idle.
`include "joystick_frame_deframer_defines.svh"

module joystick_frame_deframer (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] data_byte
    input  logic                            s_tuser,  // [0] command
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] frame_ready, [1] byte_refused, [9:2] left_vertical,
    // [17:10] left_horizontal, [25:18] right_vertical,
    // [33:26] right_horizontal, [41:34] buttons, [47:42] zero
    output logic [jfd_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [7:0]                      cfg_wdata
);

    // Parser position
    typedef enum logic [3:0] {
        POS_HUNT  = 4'd0,
        POS_SYNC  = 4'd1,
        POS_LV    = 4'd2,
        POS_LH    = 4'd3,
        POS_RV    = 4'd4,
        POS_RH    = 4'd5,
        POS_BTN   = 4'd6,
        POS_EXTRA = 4'd7,
        POS_CHECK = 4'd8
    } pos_t;

    pos_t                 pos_reg, pos_next;
    jfd_pkg::byte_t       sync_first_reg, sync_second_reg;
    jfd_pkg::byte_t       staged_reg [jfd_pkg::PAYLOAD_LEN];
    jfd_pkg::byte_t       staged_next[jfd_pkg::PAYLOAD_LEN];
    jfd_pkg::byte_t       held_reg   [jfd_pkg::PAYLOAD_LEN];
    jfd_pkg::byte_t       held_next  [jfd_pkg::PAYLOAD_LEN];
    jfd_pkg::byte_t       sum_reg, sum_next;
    logic                 ready_reg, ready_next;
    logic                 refused;
    logic                 m_tvalid_reg;
    logic [jfd_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                 s_xfer;
    jfd_pkg::cmd_t        cmd;
    jfd_pkg::byte_t       rx_byte;
    logic [jfd_pkg::SLOT_W-1:0] slot;

    assign cmd      = jfd_pkg::cmd_t'(s_tuser);
    assign rx_byte  = s_tdata;
    // Accept whenever the output register is empty or being drained
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Payload slot of the current position (valid for POS_LV..POS_BTN)
    assign slot = jfd_pkg::SLOT_W'(pos_reg - POS_LV);

    // Parser: decode one byte against the current position
    always_comb begin
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        ready_next = ready_reg;
        refused    = 1'b0;
        for (int k = 0; k < jfd_pkg::PAYLOAD_LEN; k++) begin
            staged_next[k] = staged_reg[k];
            held_next[k]   = held_reg[k];
        end
        if (cmd == jfd_pkg::CMD_ACK) begin
            ready_next = 1'b0;
        end else if (ready_reg) begin
            // Frame still held: drop nothing, consume nothing
            refused = 1'b1;
        end else begin
            unique case (pos_reg)
                POS_SYNC: begin
                    // Second sync wins when both registers match
                    priority if (rx_byte == sync_second_reg) begin
                        pos_next = POS_LV;
                    end else if (rx_byte == sync_first_reg) begin
                        pos_next = POS_SYNC;
                    end else begin
                        pos_next = POS_HUNT;
                    end
                end
                POS_LV, POS_LH, POS_RV, POS_RH, POS_BTN: begin
                    staged_next[slot] = rx_byte;
                    sum_next = (pos_reg == POS_LV) ? rx_byte : sum_reg + rx_byte;
                    pos_next = pos_t'(pos_reg + 4'd1);
                end
                POS_EXTRA: begin
                    pos_next = POS_CHECK;
                end
                POS_CHECK: begin
                    // Latch the frame even when the checksum fails
                    for (int k = 0; k < jfd_pkg::PAYLOAD_LEN; k++) begin
                        held_next[k] = staged_reg[k];
                    end
                    if (rx_byte == jfd_pkg::CHECK_BASE - sum_reg) begin
                        ready_next = 1'b1;
                    end
                    pos_next = POS_HUNT;
                end
                default: begin
                    // Hunting, and any stray code behaves the same
                    pos_next = (rx_byte == sync_first_reg) ? POS_SYNC : POS_HUNT;
                end
            endcase
        end
    end

    // Result word from the post-item state
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[jfd_pkg::OUT_READY_BIT]   = ready_next;
        m_tdata_next[jfd_pkg::OUT_REFUSED_BIT] = refused;
        for (int k = 0; k < jfd_pkg::PAYLOAD_LEN; k++) begin
            m_tdata_next[jfd_pkg::OUT_HELD_LSB + k*jfd_pkg::BYTE_W +: jfd_pkg::BYTE_W] =
                (k < jfd_pkg::AXIS_COUNT) ? (held_next[k] ^ jfd_pkg::AXIS_OFFSET)
                                          : held_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg         <= POS_HUNT;
            sum_reg         <= '0;
            ready_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            sync_first_reg  <= jfd_pkg::SYNC_FIRST_RST;
            sync_second_reg <= jfd_pkg::SYNC_SECOND_RST;
            for (int k = 0; k < jfd_pkg::PAYLOAD_LEN; k++) begin
                held_reg[k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                unique case (jfd_pkg::reg_idx_t'(cfg_index))
                    jfd_pkg::REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata;
                    jfd_pkg::REG_SYNC_SECOND: sync_second_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_xfer) begin
                pos_reg   <= pos_next;
                sum_reg   <= sum_next;
                ready_reg <= ready_next;
                for (int k = 0; k < jfd_pkg::PAYLOAD_LEN; k++) begin
                    held_reg[k] <= held_next[k];
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            for (int k = 0; k < jfd_pkg::PAYLOAD_LEN; k++) begin
                staged_reg[k] <= staged_next[k];
            end
            m_tdata_reg <= m_tdata_next;
        end
    end

    `JFD_ASSERT_NEXT(a_refused_flagged, s_xfer && cmd == jfd_pkg::CMD_DATA && ready_reg, m_tdata_reg[jfd_pkg::OUT_REFUSED_BIT] && m_tdata_reg[jfd_pkg::OUT_READY_BIT], "refused byte not reported with ready held")
    `JFD_ASSERT_NEXT(a_refused_keeps_pos, s_xfer && cmd == jfd_pkg::CMD_DATA && ready_reg, $stable(pos_reg) && $stable(sum_reg), "refused byte disturbed the parser")
    `JFD_ASSERT_NEXT(a_ack_clears, s_xfer && cmd == jfd_pkg::CMD_ACK, !ready_reg && !m_tdata_reg[jfd_pkg::OUT_REFUSED_BIT], "acknowledge did not clear ready")
    `JFD_ASSERT_NOW(a_ready_from_check, ready_reg && !$past(ready_reg), $past(pos_reg) == POS_CHECK && $past(s_xfer), "ready set outside the checksum byte")

endmodule

### tb/jfd_frame_monitor.sv
module jfd_frame_monitor
    import jfd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [7:0]            cfg_wdata,
    output int                    outstanding,
    output int                    mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] POS_HUNT  = 4'd0;
    localparam logic [3:0] POS_SYNC1 = 4'd1;
    localparam logic [3:0] POS_PAY0  = 4'd2;
    localparam logic [3:0] POS_EXTRA = 4'd7;
    localparam logic [3:0] POS_CHECK = 4'd8;

    typedef struct packed {
        logic                    ready;
        logic                    refused;
        byte_t [AXIS_COUNT-1:0]  axis;
        byte_t                   buttons;
    } joy_view_t;

    // Shadow of the parser and its registers
    byte_t      hdr_first;
    byte_t      hdr_second;
    logic [3:0] frame_pos;
    byte_t      staged [PAYLOAD_LEN];
    byte_t      staged_sum;
    byte_t      latched [PAYLOAD_LEN];
    logic       frame_held;

    joy_view_t  views_due [$];

    function automatic joy_view_t parse_transfer(cmd_t cmd, byte_t b);
        joy_view_t v;
        int        k;
        v.refused = 1'b0;
        if (cmd == CMD_ACK) begin
            frame_held = 1'b0;
        end else if (frame_held) begin
            v.refused = 1'b1;
        end else if (frame_pos == POS_SYNC1) begin
            // second sync wins over a repeated first sync
            if (b == hdr_second) begin
                frame_pos = POS_PAY0;
            end else if (b == hdr_first) begin
                frame_pos = POS_SYNC1;
            end else begin
                frame_pos = POS_HUNT;
            end
        end else if (frame_pos >= POS_PAY0 && frame_pos < POS_EXTRA) begin
            staged[frame_pos - POS_PAY0] = b;
            staged_sum = (frame_pos == POS_PAY0) ? b : byte_t'(staged_sum + b);
            frame_pos = frame_pos + 4'd1;
        end else if (frame_pos == POS_EXTRA) begin
            frame_pos = POS_CHECK;
        end else if (frame_pos == POS_CHECK) begin
            // held values follow every complete frame, good or not
            latched = staged;
            if (b == byte_t'(CHECK_BASE - staged_sum)) frame_held = 1'b1;
            frame_pos = POS_HUNT;
        end else begin
            frame_pos = (b == hdr_first) ? POS_SYNC1 : POS_HUNT;
        end
        v.ready = frame_held;
        for (k = 0; k < AXIS_COUNT; k++) v.axis[k] = latched[k] ^ AXIS_OFFSET;
        v.buttons = latched[AXIS_COUNT];
        return v;
    endfunction

    function automatic void check_field(string name, byte_t want, byte_t got);
        if (want !== got) begin
            mismatches++;
            $display("%0t ns: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        joy_view_t want;
        int        k;
        if (!aresetn) begin
            hdr_first  = SYNC_FIRST_RST;
            hdr_second = SYNC_SECOND_RST;
            frame_pos  = POS_HUNT;
            staged_sum = '0;
            frame_held = 1'b0;
            for (k = 0; k < PAYLOAD_LEN; k++) begin
                staged[k]  = '0;
                latched[k] = '0;
            end
            views_due.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_index))
                    REG_SYNC_FIRST:  hdr_first  = cfg_wdata;
                    REG_SYNC_SECOND: hdr_second = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (views_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result expected none, got 0x%012h", $time, m_tdata);
                end else begin
                    want = views_due.pop_front();
                    check_field("frame_ready", byte_t'(want.ready),
                                byte_t'(m_tdata[OUT_READY_BIT]));
                    check_field("byte_refused", byte_t'(want.refused),
                                byte_t'(m_tdata[OUT_REFUSED_BIT]));
                    check_field("left_vertical", want.axis[0],
                                m_tdata[OUT_HELD_LSB +: BYTE_W]);
                    check_field("left_horizontal", want.axis[1],
                                m_tdata[OUT_HELD_LSB + BYTE_W +: BYTE_W]);
                    check_field("right_vertical", want.axis[2],
                                m_tdata[OUT_HELD_LSB + 2*BYTE_W +: BYTE_W]);
                    check_field("right_horizontal", want.axis[3],
                                m_tdata[OUT_HELD_LSB + 3*BYTE_W +: BYTE_W]);
                    check_field("buttons", want.buttons,
                                m_tdata[OUT_HELD_LSB + 4*BYTE_W +: BYTE_W]);
                    check_field("padding", '0, byte_t'(m_tdata[OUT_DATA_W-1:OUT_USED_W]));
                end
            end
            if (s_tvalid && s_tready)
                views_due.push_back(parse_transfer(cmd_t'(s_tuser), s_tdata));
            outstanding <= views_due.size();
        end
    end

endmodule

### tb/joystick_frame_deframer_tb.sv
module joystick_frame_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jfd_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 300;
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int STUCK_LIMIT = 2000;  // cycles without any transfer

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] data_byte
    logic                  s_tuser;   // [0] command
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] frame_ready, [1] byte_refused, [9:2] left_vertical, [17:10] left_horizontal,
    // [25:18] right_vertical, [33:26] right_horizontal, [41:34] buttons, [47:42] zero
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    logic                  cfg_index;
    logic [7:0]            cfg_wdata;

    int    mismatches;
    int    outstanding;
    int    items_sent;
    int    stuck_cycles;
    bit    calm;        // no idling on either side
    bit    long_hold;   // ask the receiver for one long hold-off
    byte_t sync_first_v;
    byte_t sync_second_v;

    joystick_frame_deframer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    jfd_frame_monitor frame_mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Receiver: ready in random stretches and random stalls, one long
    // hold-off on request. Each pass drives m_tready once, then lets time advance.
    initial begin
        int span;
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                span = HOLD_CYCLES;
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                span = $urandom_range(1, 12);
            end else begin
                m_tready <= 1'b1;
                span = calm ? 1 : $urandom_range(1, 16);
            end
            repeat (span) @(posedge aclk);
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("joystick_frame_deframer_tb failed");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer; sometimes idle first.
    // Called at a rising edge, returns at the edge of the transfer.
    task automatic offer(input cmd_t cmd, input byte_t b);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop offering and wait until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Write both sync registers on consecutive edges; only while idle
    task automatic write_syncs(input byte_t first, input byte_t second);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SYNC_FIRST;
        cfg_wdata <= first;
        @(posedge aclk);
        cfg_index <= REG_SYNC_SECOND;
        cfg_wdata <= second;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sync_first_v  = first;
        sync_second_v = second;
    endtask

    // Payload byte with a bias towards the edges of the axis range
    function automatic byte_t pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            default: return byte_t'($urandom);
        endcase
    endfunction

    // Whole frame: header (optionally with repeated first sync), payload,
    // extra byte and a checksum that is either right or deliberately off
    task automatic send_frame(input bit good_sum, input bit repeat_first);
        byte_t b;
        byte_t sum;
        int    k;
        offer(CMD_DATA, sync_first_v);
        if (repeat_first) repeat ($urandom_range(1, 3)) offer(CMD_DATA, sync_first_v);
        offer(CMD_DATA, sync_second_v);
        sum = '0;
        for (k = 0; k < PAYLOAD_LEN; k++) begin
            b   = pick_byte();
            sum = sum + b;
            offer(CMD_DATA, b);
        end
        offer(CMD_DATA, pick_byte());
        b = CHECK_BASE - sum;
        if (!good_sum) b = b ^ byte_t'($urandom_range(1, 255));
        offer(CMD_DATA, b);
    endtask

    // One random episode: mostly well-formed frames, then bad checksums,
    // truncated headers and payloads, line noise and stray acknowledges
    task automatic random_episode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            send_frame(1'b1, $urandom_range(0, 3) == 0);
        end else if (r < 67) begin
            send_frame(1'b0, 1'b0);
        end else if (r < 77) begin
            offer(CMD_DATA, sync_first_v);
            if ($urandom_range(0, 1) == 1) offer(CMD_DATA, sync_second_v);
            repeat ($urandom_range(0, 4)) offer(CMD_DATA, pick_byte());
        end else if (r < 87) begin
            repeat ($urandom_range(1, 6)) offer(CMD_DATA, byte_t'($urandom));
        end else begin
            offer(CMD_ACK, byte_t'($urandom));
        end
        // release a held frame most of the time, now and then after bytes it refuses
        if ($urandom_range(0, 4) != 0) begin
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) offer(CMD_DATA, byte_t'($urandom));
            offer(CMD_ACK, byte_t'($urandom));
        end
    endtask

    initial begin
        int  ph;
        int  phase_end;
        bit  paused;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_DATA;
        cfg_we       = 1'b0;
        cfg_index    = REG_SYNC_FIRST;
        cfg_wdata    = '0;
        items_sent   = 0;
        stuck_cycles = 0;
        calm         = 1'b0;
        long_hold    = 1'b0;
        paused       = 1'b0;
        sync_first_v  = SYNC_FIRST_RST;
        sync_second_v = SYNC_SECOND_RST;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, sync bytes at their reset values.
        // Acknowledge with nothing held: ready stays clear.
        offer(CMD_ACK, 8'h00);
        // Repeated first sync keeps the hunt alive, then the header completes
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'h55);
        // Axes at the range edges; sum 0x1FF wraps to 0xFF, checksum 0x00
        offer(CMD_DATA, 8'h00);
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'h80);
        offer(CMD_DATA, 8'h7F);
        offer(CMD_DATA, 8'h01);
        offer(CMD_DATA, 8'hAA);
        offer(CMD_DATA, 8'h00);
        // Frame held: this byte is refused, then release it
        offer(CMD_DATA, 8'hFF);
        offer(CMD_ACK, 8'hFF);
        // Bad checksum: held values move on, ready stays clear
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'h55);
        offer(CMD_DATA, 8'h10);
        offer(CMD_DATA, 8'h20);
        offer(CMD_DATA, 8'h30);
        offer(CMD_DATA, 8'h40);
        offer(CMD_DATA, 8'h50);
        offer(CMD_DATA, 8'h00);
        offer(CMD_DATA, 8'h0E);
        // First sync followed by a stranger: back to hunting
        offer(CMD_DATA, 8'hFF);
        offer(CMD_DATA, 8'h12);

        // Random phases, one sync setting each; the last one runs without idling
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                drain();
                case (ph)
                    1:       write_syncs(8'h00, 8'h00);   // both sync bytes equal
                    2:       write_syncs(8'hFF, 8'h00);
                    3:       write_syncs(byte_t'($urandom), byte_t'($urandom));
                    4:       write_syncs(8'h00, 8'hFF);
                    default: write_syncs(SYNC_FIRST_RST, SYNC_SECOND_RST);
                endcase
            end
            calm = (ph == PHASES - 1);
            // hold the receiver off while the sender keeps pushing
            if (ph == 1) long_hold = 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                // pause the sender once mid-phase until everything is back
                if (ph == 2 && !paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
                    drain();
                    paused = 1'b1;
                end
                random_episode();
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("joystick_frame_deframer_tb passed");
        end else begin
            $display("joystick_frame_deframer_tb failed");
        end
        $finish;
    end

endmodule
